FILE: sv/api_frame_builder_defines.svh
// Assertion macros used by the checker file afb_checker.sv.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef API_FRAME_BUILDER_DEFINES_SVH
`define API_FRAME_BUILDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("api_frame_builder check failed");

// The consequent must hold in the cycle after the antecedent.
`define AFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("api_frame_builder check failed");

`endif

FILE: sv/afb_pkg.sv
// ----------------------------------------------------------------------------
// afb_pkg
// Types, codes and header byte lookup of the API frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package afb_pkg;

    localparam int unsigned MaxData = 255;

    // Frame kinds as carried on the input.
    localparam logic [1:0] KIND_AT_CMD   = 2'd0;
    localparam logic [1:0] KIND_AT_QUEUE = 2'd1;
    localparam logic [1:0] KIND_TX_REQ   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_AT_FRAME_ID      = 2'd0;
    localparam logic [1:0] REG_TX_FRAME_ID      = 2'd1;
    localparam logic [1:0] REG_BROADCAST_RADIUS = 2'd2;
    localparam logic [1:0] REG_TRANSMIT_OPTIONS = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] AT_FRAME_ID_RST      = 8'h52;
    localparam logic [7:0] TX_FRAME_ID_RST      = 8'h01;
    localparam logic [7:0] BROADCAST_RADIUS_RST = 8'h00;
    localparam logic [7:0] TRANSMIT_OPTIONS_RST = 8'h00;

    // Frame bytes.
    localparam logic [7:0] START_DELIM   = 8'h7E;
    localparam logic [7:0] TYPE_AT_CMD   = 8'h08;
    localparam logic [7:0] TYPE_AT_QUEUE = 8'h09;
    localparam logic [7:0] TYPE_TX_REQ   = 8'h10;
    localparam logic [7:0] NET_ADDR_HI   = 8'hFF;
    localparam logic [7:0] NET_ADDR_LO   = 8'hFE;
    localparam logic [7:0] CHECKSUM_BASE = 8'hFF;

    // Length field offsets and header sizes including delimiter and length.
    localparam logic [15:0] LEN_AT_OFFSET = 16'd4;
    localparam logic [15:0] LEN_TX_OFFSET = 16'd14;
    localparam logic [4:0]  HDR_AT_BYTES  = 5'd7;
    localparam logic [4:0]  HDR_TX_BYTES  = 5'd17;
    localparam logic [4:0]  HDR_SUM_START = 5'd3;

    localparam int unsigned PosWidth = 5;

    typedef logic [PosWidth-1:0] pos_t;

    typedef struct packed {
        logic [7:0] at_frame_id;
        logic [7:0] tx_frame_id;
        logic [7:0] broadcast_radius;
        logic [7:0] transmit_options;
    } cfg_t;

    // Byte at a given position of the header, delimiter and length included.
    function automatic logic [7:0] header_byte(
        input pos_t        pos,
        input logic        tx,
        input logic        queue,
        input logic [15:0] len,
        input logic [63:0] addr,
        input logic [15:0] cmd,
        input cfg_t        cfg
    );
        logic [7:0] b;
        b = 8'h00;
        case (pos)
            5'd0:  b = START_DELIM;
            5'd1:  b = len[15:8];
            5'd2:  b = len[7:0];
            5'd3:  b = tx ? TYPE_TX_REQ : (queue ? TYPE_AT_QUEUE : TYPE_AT_CMD);
            5'd4:  b = tx ? cfg.tx_frame_id : cfg.at_frame_id;
            5'd5:  b = tx ? addr[63:56] : cmd[15:8];
            5'd6:  b = tx ? addr[55:48] : cmd[7:0];
            5'd7:  b = addr[47:40];
            5'd8:  b = addr[39:32];
            5'd9:  b = addr[31:24];
            5'd10: b = addr[23:16];
            5'd11: b = addr[15:8];
            5'd12: b = addr[7:0];
            5'd13: b = NET_ADDR_HI;
            5'd14: b = NET_ADDR_LO;
            5'd15: b = cfg.broadcast_radius;
            5'd16: b = cfg.transmit_options;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/api_frame_builder.sv
// ----------------------------------------------------------------------------
// api_frame_builder
// Turns items into API frames on a byte stream with a running checksum.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_stall       frame_kind .. last_item
//  out       output     out_valid / out_stall     out_byte, frame_end, run_end
//  cfg       input      cfg_write                 cfg_index, cfg_data
//
// An item yields its bytes one per cycle while out_stall lets them move; an item
// that yields none is not held. A data item yields one byte, an opening item up
// to 19 (delimiter, length, header, data, checksum). The next item is taken in
// the cycle that its predecessor's last byte moves out.
// Reset clears the pipeline, closes any open frame and restores the registers.
// While out_stall is high the output byte holds and in_stall rises as soon as
// the item register cannot drain.
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_builder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  frame_kind,
    input  wire logic [63:0] dest_address,
    input  wire logic [15:0] at_command,
    input  wire logic [7:0]  data_count,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_data,
    input  wire logic        first_item,
    input  wire logic        last_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             frame_end,
    output logic             run_end,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import afb_pkg::*;

    typedef struct packed {
        logic        hdr;
        logic        tx;
        logic        queue;
        logic        dat;
        pos_t        last_pos;
        logic [15:0] len;
        logic [63:0] addr;
        logic [15:0] cmd;
        logic [7:0]  data;
    } item_t;

    cfg_t        cfg_reg;
    logic        in_frame_reg;
    logic [7:0]  sum_reg;
    logic        it_valid_reg;
    pos_t        pos_reg;
    item_t       it_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        frame_end_reg;
    logic        run_end_reg;

    logic        accept;
    logic        open_now;
    logic        new_tx;
    logic        new_dat;
    logic        new_chk;
    pos_t        new_hdr_len;
    pos_t        new_count;
    logic [15:0] count_sat;
    item_t       new_item;

    logic        move;
    logic        done;
    pos_t        hdr_len;
    logic        in_hdr;
    logic        is_data;
    logic        summed;
    logic [7:0]  cur_byte;
    logic [7:0]  sum_next;

    // Decode of the incoming item.
    always_comb
    begin
        open_now    = first_item || in_frame_reg;
        new_tx      = (frame_kind == KIND_TX_REQ);
        new_dat     = has_data && open_now;
        new_chk     = last_item && open_now;
        new_hdr_len = first_item ? (new_tx ? HDR_TX_BYTES : HDR_AT_BYTES) : '0;
        new_count   = new_hdr_len + pos_t'(new_dat) + pos_t'(new_chk);
        count_sat   = ({8'h00, data_count} > 16'(MaxData)) ? 16'(MaxData)
                                                          : {8'h00, data_count};
        new_item.hdr      = first_item;
        new_item.tx       = new_tx;
        new_item.queue    = (frame_kind == KIND_AT_QUEUE);
        new_item.dat      = new_dat;
        new_item.last_pos = new_count - pos_t'(1);
        new_item.len      = count_sat + (new_tx ? LEN_TX_OFFSET : LEN_AT_OFFSET);
        new_item.addr     = dest_address;
        new_item.cmd      = at_command;
        new_item.data     = data_byte;
    end

    // Selection of the byte at the current position of the held item.
    always_comb
    begin
        hdr_len  = it_reg.hdr ? (it_reg.tx ? HDR_TX_BYTES : HDR_AT_BYTES) : '0;
        in_hdr   = pos_reg < hdr_len;
        is_data  = !in_hdr && it_reg.dat && (pos_reg == hdr_len);
        summed   = in_hdr ? (pos_reg >= HDR_SUM_START) : is_data;
        if (in_hdr)
        begin
            cur_byte = header_byte(pos_reg, it_reg.tx, it_reg.queue, it_reg.len,
                                   it_reg.addr, it_reg.cmd, cfg_reg);
        end
        else if (is_data)
        begin
            cur_byte = it_reg.data;
        end
        else
        begin
            cur_byte = CHECKSUM_BASE - sum_reg;
        end

        // The delimiter opens a fresh sum.
        if (in_hdr && (pos_reg == '0))
        begin
            sum_next = 8'h00;
        end
        else if (summed)
        begin
            sum_next = sum_reg + cur_byte;
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    assign move     = it_valid_reg && (!out_valid_reg || !out_stall);
    assign done     = move && (pos_reg == it_reg.last_pos);
    assign in_stall = it_valid_reg && !done;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.at_frame_id      <= AT_FRAME_ID_RST;
            cfg_reg.tx_frame_id      <= TX_FRAME_ID_RST;
            cfg_reg.broadcast_radius <= BROADCAST_RADIUS_RST;
            cfg_reg.transmit_options <= TRANSMIT_OPTIONS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AT_FRAME_ID:      cfg_reg.at_frame_id      <= cfg_data;
                REG_TX_FRAME_ID:      cfg_reg.tx_frame_id      <= cfg_data;
                REG_BROADCAST_RADIUS: cfg_reg.broadcast_radius <= cfg_data;
                REG_TRANSMIT_OPTIONS: cfg_reg.transmit_options <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            sum_reg       <= 8'h00;
            it_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_frame_reg <= open_now && !last_item;
            end

            if (move)
            begin
                sum_reg <= sum_next;
            end

            if (accept && (new_count != '0))
            begin
                it_valid_reg <= 1'b1;
                pos_reg      <= '0;
            end
            else if (done)
            begin
                it_valid_reg <= 1'b0;
            end
            else if (move)
            begin
                pos_reg <= pos_reg + pos_t'(1);
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && (new_count != '0))
        begin
            it_reg <= new_item;
        end
        if (move)
        begin
            out_byte_reg  <= cur_byte;
            frame_end_reg <= !in_hdr && !is_data;
            run_end_reg   <= (pos_reg == it_reg.last_pos);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign run_end   = run_end_reg;

endmodule

`default_nettype wire

FILE: sv/afb_checker.sv
// ----------------------------------------------------------------------------
// afb_checker
// Port-level checks of the API frame builder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "api_frame_builder_defines.svh"

module afb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       frame_end,
    input wire logic       run_end
);

    // A held output byte must not change while the receiver stalls.
    `AFB_ASSERT_NEXT(out_hold_chk, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(frame_end) && $stable(run_end))

    // The checksum is always the final byte an item produces.
    `AFB_ASSERT_NOW(chk_last_chk, out_valid && frame_end, run_end)

    // An item cannot drain while the output is blocked.
    `AFB_ASSERT_NEXT(drain_chk, out_valid && out_stall && in_stall, in_stall || !out_stall)

endmodule

bind api_frame_builder afb_checker u_afb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .run_end   (run_end)
);

`default_nettype wire

FILE: test/tb_api_frame_builder.sv
// ----------------------------------------------------------------------------
// tb_api_frame_builder
// Drives items into the API frame builder and checks every byte of the frames
// it puts on the wire. A table of directed items runs first, then random
// frames under several register settings, with bursty input, a stalling
// receiver, one long receiver hold-off and one full drain in mid phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_api_frame_builder;

    timeunit 1ns;
    timeprecision 1ps;

    import afb_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int SETTLE_CYCLES        = 40;
    localparam int HOLD_CYCLES          = 300;
    localparam int QUIET_LIMIT          = 2000;
    localparam int FRAMES_PER_PHASE     = 48;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [63:0] dest_address;
        logic [15:0] at_command;
        logic [7:0]  data_count;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        first_item;
        logic        last_item;
    } item_t;

    typedef struct packed {
        item_t      it;
        logic       typed;
        logic [7:0] tail;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] value;
        logic       fend;
        logic       rend;
    } wire_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  frame_kind;
    logic [63:0] dest_address;
    logic [15:0] at_command;
    logic [7:0]  data_count;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        first_item;
    logic        last_item;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        run_end;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Predictor copy of the registers and the frame state.
    logic [7:0] reg_at_id;
    logic [7:0] reg_tx_id;
    logic [7:0] reg_radius;
    logic [7:0] reg_options;
    logic [7:0] sum_acc;
    logic       frame_open;

    wire_byte_t pending_bytes[$];
    dir_row_t   dir_table[$];
    int         n_bad;
    int         n_fed;
    int         burst_left;
    int         quiet;
    logic       hold_req;

    api_frame_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_kind   (frame_kind),
        .dest_address (dest_address),
        .at_command   (at_command),
        .data_count   (data_count),
        .data_byte    (data_byte),
        .has_data     (has_data),
        .first_item   (first_item),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .frame_end    (frame_end),
        .run_end      (run_end),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void push_byte(input logic [7:0] b, input logic summed,
                                      input logic fend);
        wire_byte_t wb;
        wb.value = b;
        wb.fend  = fend;
        wb.rend  = 1'b0;
        pending_bytes.push_back(wb);
        if (summed)
        begin
            sum_acc = sum_acc + b;
        end
    endfunction

    // Appends the wire bytes that one item yields; returns how many.
    function automatic int emit_frame_bytes(input item_t it);
        int          base;
        int          i;
        logic [15:0] len;
        wire_byte_t  wb;
        base = pending_bytes.size();
        if (it.first_item)
        begin
            sum_acc    = 8'h00;
            frame_open = 1'b1;
            len = ((it.frame_kind == KIND_TX_REQ) ? LEN_TX_OFFSET : LEN_AT_OFFSET)
                  + {8'h00, it.data_count};
            push_byte(START_DELIM, 1'b0, 1'b0);
            push_byte(len[15:8], 1'b0, 1'b0);
            push_byte(len[7:0], 1'b0, 1'b0);
            if (it.frame_kind == KIND_TX_REQ)
            begin
                push_byte(TYPE_TX_REQ, 1'b1, 1'b0);
                push_byte(reg_tx_id, 1'b1, 1'b0);
                for (i = 7; i >= 0; i--)
                begin
                    push_byte(it.dest_address[8*i +: 8], 1'b1, 1'b0);
                end
                push_byte(NET_ADDR_HI, 1'b1, 1'b0);
                push_byte(NET_ADDR_LO, 1'b1, 1'b0);
                push_byte(reg_radius, 1'b1, 1'b0);
                push_byte(reg_options, 1'b1, 1'b0);
            end
            else
            begin
                // The unused kind falls back to a plain AT command.
                push_byte((it.frame_kind == KIND_AT_QUEUE) ? TYPE_AT_QUEUE : TYPE_AT_CMD,
                          1'b1, 1'b0);
                push_byte(reg_at_id, 1'b1, 1'b0);
                push_byte(it.at_command[15:8], 1'b1, 1'b0);
                push_byte(it.at_command[7:0], 1'b1, 1'b0);
            end
        end
        if (it.has_data && frame_open)
        begin
            push_byte(it.data_byte, 1'b1, 1'b0);
        end
        if (it.last_item && frame_open)
        begin
            push_byte(CHECKSUM_BASE - sum_acc, 1'b0, 1'b1);
            frame_open = 1'b0;
        end
        if (pending_bytes.size() > base)
        begin
            wb      = pending_bytes.pop_back();
            wb.rend = 1'b1;
            pending_bytes.push_back(wb);
        end
        return pending_bytes.size() - base;
    endfunction

    function automatic dir_row_t dir_row(input logic [1:0] kind, input logic [63:0] addr,
                                         input logic [15:0] cmd, input logic [7:0] cnt,
                                         input logic [7:0] dbyte, input logic hd,
                                         input logic fi, input logic li,
                                         input logic typed, input logic [7:0] tail);
        dir_row_t r;
        r.it.frame_kind   = kind;
        r.it.dest_address = addr;
        r.it.at_command   = cmd;
        r.it.data_count   = cnt;
        r.it.data_byte    = dbyte;
        r.it.has_data     = hd;
        r.it.first_item   = fi;
        r.it.last_item    = li;
        r.typed           = typed;
        r.tail            = tail;
        return r;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.frame_kind   = 2'($urandom_range(0, 3));
        it.dest_address = {$urandom, $urandom};
        it.at_command   = 16'($urandom);
        it.data_count   = 8'($urandom_range(0, 255));
        it.data_byte    = 8'($urandom_range(0, 255));
        it.has_data     = 1'($urandom_range(0, 1));
        it.first_item   = 1'($urandom_range(0, 1));
        it.last_item    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Sender bursts: a random gap opens each burst.
    task automatic pace();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic offer(input item_t it, input logic typed, input logic [7:0] tail);
        wire_byte_t wb;
        pace();
        in_valid     <= 1'b1;
        frame_kind   <= it.frame_kind;
        dest_address <= it.dest_address;
        at_command   <= it.at_command;
        data_count   <= it.data_count;
        data_byte    <= it.data_byte;
        has_data     <= it.has_data;
        first_item   <= it.first_item;
        last_item    <= it.last_item;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (emit_frame_bytes(it) != 0)
        begin
            n_fed++;
            // A typed-in row fixes the final byte of what this item yields.
            if (typed)
            begin
                wb       = pending_bytes.pop_back();
                wb.value = tail;
                pending_bytes.push_back(wb);
            end
        end
    endtask

    task automatic send_frame();
        item_t it;
        int    nd;
        int    roll;
        int    i;
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            offer(rand_item(), 1'b0, 8'h00);
        end
        else
        begin
            it            = rand_item();
            it.first_item = 1'b1;
            it.last_item  = ($urandom_range(0, 9) == 0);
            offer(it, 1'b0, 8'h00);
            if (!it.last_item)
            begin
                nd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 5);
                for (i = 0; i < nd; i++)
                begin
                    it            = rand_item();
                    it.first_item = 1'b0;
                    it.last_item  = 1'b0;
                    it.has_data   = ($urandom_range(0, 7) != 0);
                    offer(it, 1'b0, 8'h00);
                end
                // Some frames are left open so the next one reopens them.
                if (roll >= 20)
                begin
                    it            = rand_item();
                    it.first_item = 1'b0;
                    it.last_item  = 1'b1;
                    offer(it, 1'b0, 8'h00);
                end
            end
        end
    endtask

    task automatic run_frames(input int target);
        int goal;
        goal = n_fed + target;
        while (n_fed < goal)
        begin
            send_frame();
        end
    endtask

    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
        end
        while (pending_bytes.size() != 0);
    endtask

    task automatic program_regs(input logic [7:0] at_id, input logic [7:0] tx_id,
                                input logic [7:0] radius, input logic [7:0] options);
        logic [7:0] vals [4];
        int         i;
        vals[0] = at_id;
        vals[1] = tx_id;
        vals[2] = radius;
        vals[3] = options;
        wait_drained();
        // A closing item outside a frame yields nothing, so let the block settle.
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write   <= 1'b0;
        reg_at_id   = at_id;
        reg_tx_id   = tx_id;
        reg_radius  = radius;
        reg_options = options;
    endtask

    // Receiver: stall pattern that changes mode now and then, plus one hold-off.
    initial
    begin : rx_pace
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left  = 0;
        out_stall  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_out
        wire_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("out_byte: expected nothing, actual %h", out_byte);
                n_bad++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    $error("out_byte: expected %h, actual %h", want.value, out_byte);
                    n_bad++;
                end
                if (frame_end !== want.fend)
                begin
                    $error("frame_end: expected %b, actual %b", want.fend, frame_end);
                    n_bad++;
                end
                if (run_end !== want.rend)
                begin
                    $error("run_end: expected %b, actual %b", want.rend, run_end);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        frame_kind   = KIND_AT_CMD;
        dest_address = 64'h0;
        at_command   = 16'h0;
        data_count   = 8'h00;
        data_byte    = 8'h00;
        has_data     = 1'b0;
        first_item   = 1'b0;
        last_item    = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_AT_FRAME_ID;
        cfg_data     = 8'h00;
        hold_req     = 1'b0;
        n_bad        = 0;
        n_fed        = 0;
        burst_left   = 0;
        quiet        = 0;
        reg_at_id    = AT_FRAME_ID_RST;
        reg_tx_id    = TX_FRAME_ID_RST;
        reg_radius   = BROADCAST_RADIUS_RST;
        reg_options  = TRANSMIT_OPTIONS_RST;
        sum_acc      = 8'h00;
        frame_open   = 1'b0;

        // Directed items; registers are at their reset values here.
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0000, 8'd0, 8'h00,
                                    1'b0, 1'b1, 1'b1, 1'b1, 8'hA5));
        dir_table.push_back(dir_row(KIND_UNUSED, 64'h0, 16'h0000, 8'd0, 8'h00,
                                    1'b0, 1'b1, 1'b1, 1'b1, 8'hA5));
        dir_table.push_back(dir_row(KIND_TX_REQ, 64'h0, 16'h0000, 8'd0, 8'h00,
                                    1'b0, 1'b1, 1'b1, 1'b1, 8'hF1));
        // Data and close with no frame open, then an idle item.
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'hAA,
                                    1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h00,
                                    1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h00,
                                    1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_QUEUE, {64{1'b1}}, 16'hFFFF, 8'd255, 8'hFF,
                                    1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h00,
                                    1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h80,
                                    1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h00,
                                    1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_TX_REQ, {64{1'b1}}, 16'hFFFF, 8'd255, 8'h55,
                                    1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h4944, 8'd3, 8'h01,
                                    1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
        // Reopen: a new frame while the previous one is still open.
        dir_table.push_back(dir_row(KIND_TX_REQ, 64'h0123_4567_89AB_CDEF, 16'h0, 8'd2,
                                    8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h7F,
                                    1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'hFE,
                                    1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
        // Count mismatches in both directions.
        dir_table.push_back(dir_row(KIND_AT_QUEUE, 64'h0, 16'h4E49, 8'd0, 8'h33,
                                    1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h5348, 8'd1, 8'h00,
                                    1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h11,
                                    1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h22,
                                    1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h33,
                                    1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_TX_REQ, 64'hAAAA_AAAA_5555_5555, 16'h0, 8'd128,
                                    8'hC3, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
        dir_table.push_back(dir_row(KIND_AT_CMD, 64'h0, 16'h0, 8'd0, 8'h3C,
                                    1'b1, 1'b0, 1'b1, 1'b0, 8'h00));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_table.size(); i++)
        begin
            offer(dir_table[i].it, dir_table[i].typed, dir_table[i].tail);
        end
        run_frames(FRAMES_PER_PHASE);

        program_regs(8'h00, 8'h00, 8'h00, 8'h00);
        run_frames(FRAMES_PER_PHASE);

        // All ones, with the receiver held off while items keep coming.
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        hold_req = 1'b1;
        run_frames(FRAMES_PER_PHASE);

        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_frames(FRAMES_PER_PHASE / 2);
        wait_drained();
        run_frames(FRAMES_PER_PHASE / 2);

        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_frames(FRAMES_PER_PHASE);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_bad == 0 && pending_bytes.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/afb_pkg.sv
sv/api_frame_builder.sv
sv/afb_checker.sv
test/tb_api_frame_builder.sv
